[rtl/core/rts_pkg.sv]
// Shared widths, register codes and types of the rigid transform point stream.
// Used by every module in rtl/core; depends on nothing.
package rts_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned QuatW   = 16;
  localparam int unsigned QFrac   = QuatW - 2;
  localparam int unsigned TermW   = QuatW + 2;
  localparam int unsigned DiffW   = CoordW + 1;
  localparam int unsigned ProdW   = TermW + DiffW;
  localparam int unsigned SumW    = ProdW + 2;
  localparam int unsigned RndW    = SumW - QFrac;
  localparam int unsigned TotW    = RndW + 1;
  localparam int unsigned CfgW    = CoordW;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_QUAT_X  = 3'd0,
    REG_QUAT_Y  = 3'd1,
    REG_QUAT_Z  = 3'd2,
    REG_QUAT_W  = 3'd3,
    REG_SHIFT_X = 3'd4,
    REG_SHIFT_Y = 3'd5,
    REG_SHIFT_Z = 3'd6,
    REG_INVERSE = 3'd7
  } cfg_idx_e;

  typedef logic signed [TermW-1:0] term_t;
  typedef term_t [8:0] matrix_t;

  typedef struct packed {
    logic signed [QuatW-1:0] x;
    logic signed [QuatW-1:0] y;
    logic signed [QuatW-1:0] z;
    logic signed [QuatW-1:0] w;
  } quat_t;

  typedef struct packed {
    logic [2:0][CoordW-1:0] shift;
    logic                   inverse;
  } xform_cfg_t;

endpackage

[rtl/core/rts_rotation.sv]
// Rotation matrix derivation from the quaternion registers, two register stages.
// Depends on rts_pkg.
module rts_rotation (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rts_pkg::quat_t quat_i,
  output rts_pkg::matrix_t matrix_o
);

  localparam int unsigned PW = 2 * rts_pkg::QuatW;
  localparam int unsigned VW = PW + 3;
  localparam int unsigned RW = VW - rts_pkg::QFrac;
  localparam int unsigned TW = rts_pkg::TermW;

  localparam logic signed [VW-1:0] OneSq =
    {{(VW-1-2*rts_pkg::QFrac){1'b0}}, 1'b1, {(2*rts_pkg::QFrac){1'b0}}};
  localparam logic signed [VW-1:0] Half =
    {{(VW-rts_pkg::QFrac){1'b0}}, 1'b1, {(rts_pkg::QFrac-1){1'b0}}};
  localparam logic signed [TW-1:0] TermMax = {1'b0, {(TW-1){1'b1}}};
  localparam logic signed [TW-1:0] TermMin = {1'b1, {(TW-1){1'b0}}};
  localparam logic signed [PW-1:0] WwReset = OneSq[PW-1:0];

  function automatic rts_pkg::term_t make_term(logic signed [PW-1:0] a,
                                               logic signed [PW-1:0] b,
                                               logic sub_b,
                                               logic minus_one);
    logic signed [PW:0]   s;
    logic signed [VW-1:0] v;
    logic signed [RW-1:0] r;
    logic [RW-TW:0]       top;
    s = sub_b ? ({a[PW-1], a} - {b[PW-1], b}) : ({a[PW-1], a} + {b[PW-1], b});
    v = {{2{s[PW]}}, s} <<< 1;
    if (minus_one) begin
      v = v - OneSq;
    end
    v = v + Half;
    r = v[VW-1:rts_pkg::QFrac];
    top = r[RW-1:TW-1];
    if ((&top) || !(|top)) begin
      make_term = r[TW-1:0];
    end else if (r[RW-1]) begin
      make_term = TermMin;
    end else begin
      make_term = TermMax;
    end
  endfunction

  logic signed [PW-1:0] ww_q, xx_q, yy_q, zz_q, xy_q, wz_q, xz_q, wy_q, yz_q, wx_q;
  logic signed [PW-1:0] ww_d, xx_d, yy_d, zz_d, xy_d, wz_d, xz_d, wy_d, yz_d, wx_d;
  rts_pkg::matrix_t matrix_q, matrix_d;

  always_comb begin
    ww_d = quat_i.w * quat_i.w;
    xx_d = quat_i.x * quat_i.x;
    yy_d = quat_i.y * quat_i.y;
    zz_d = quat_i.z * quat_i.z;
    xy_d = quat_i.x * quat_i.y;
    wz_d = quat_i.w * quat_i.z;
    xz_d = quat_i.x * quat_i.z;
    wy_d = quat_i.w * quat_i.y;
    yz_d = quat_i.y * quat_i.z;
    wx_d = quat_i.w * quat_i.x;
  end

  always_comb begin
    matrix_d[0] = make_term(ww_q, xx_q, 1'b0, 1'b1);
    matrix_d[1] = make_term(xy_q, wz_q, 1'b1, 1'b0);
    matrix_d[2] = make_term(xz_q, wy_q, 1'b0, 1'b0);
    matrix_d[3] = make_term(xy_q, wz_q, 1'b0, 1'b0);
    matrix_d[4] = make_term(ww_q, yy_q, 1'b0, 1'b1);
    matrix_d[5] = make_term(yz_q, wx_q, 1'b1, 1'b0);
    matrix_d[6] = make_term(xz_q, wy_q, 1'b1, 1'b0);
    matrix_d[7] = make_term(yz_q, wx_q, 1'b0, 1'b0);
    matrix_d[8] = make_term(ww_q, zz_q, 1'b0, 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ww_q <= WwReset;
      xx_q <= '0;
      yy_q <= '0;
      zz_q <= '0;
      xy_q <= '0;
      wz_q <= '0;
      xz_q <= '0;
      wy_q <= '0;
      yz_q <= '0;
      wx_q <= '0;
      for (int i = 0; i < 9; i++) begin
        matrix_q[i] <= (i % 4 == 0) ? make_term(WwReset, '0, 1'b0, 1'b1) : '0;
      end
    end else begin
      ww_q     <= ww_d;
      xx_q     <= xx_d;
      yy_q     <= yy_d;
      zz_q     <= zz_d;
      xy_q     <= xy_d;
      wz_q     <= wz_d;
      xz_q     <= xz_d;
      wy_q     <= wy_d;
      yz_q     <= yz_d;
      wx_q     <= wx_d;
      matrix_q <= matrix_d;
    end
  end

  assign matrix_o = matrix_q;

endmodule

[rtl/core/rts_datapath.sv]
// Five-stage point pipeline: offset, matrix products, rounded sum, translate and clamp.
// Depends on rts_pkg; matrix comes from rts_rotation.
module rts_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rts_pkg::matrix_t                matrix_i,
  input  rts_pkg::xform_cfg_t             cfg_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [2:0][rts_pkg::CoordW-1:0] in_point_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [2:0][rts_pkg::CoordW-1:0] out_point_o,
  output logic                            out_ovf_o
);

  localparam int unsigned CW = rts_pkg::CoordW;
  localparam int unsigned DW = rts_pkg::DiffW;
  localparam int unsigned PW = rts_pkg::ProdW;
  localparam int unsigned SW = rts_pkg::SumW;
  localparam int unsigned RW = rts_pkg::RndW;
  localparam int unsigned TW = rts_pkg::TotW;

  localparam logic signed [SW-1:0] Half =
    {{(SW-rts_pkg::QFrac){1'b0}}, 1'b1, {(rts_pkg::QFrac-1){1'b0}}};
  localparam logic signed [CW-1:0] CMax = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMin = {1'b1, {(CW-1){1'b0}}};

  logic [5:1] vld_q, vld_d, en;

  logic signed [CW-1:0] pt_q   [3];
  logic signed [DW-1:0] diff_q [3], diff_d [3];
  logic signed [PW-1:0] prod_q [9], prod_d [9];
  logic signed [RW-1:0] rnd_q  [3], rnd_d  [3];
  logic signed [CW-1:0] out_q  [3], out_d  [3];
  logic                 ovf_q, ovf_d;

  // advance a stage when it is empty or its word moves on
  always_comb begin
    en[5] = !vld_q[5] || out_ready_i;
    for (int s = 4; s >= 1; s--) begin
      en[s] = !vld_q[s] || en[s+1];
    end
    vld_d[1] = en[1] ? in_valid_i : vld_q[1];
    for (int s = 2; s <= 5; s++) begin
      vld_d[s] = en[s] ? vld_q[s-1] : vld_q[s];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff_d[k] = cfg_i.inverse ?
                  ({pt_q[k][CW-1], pt_q[k]} -
                   {cfg_i.shift[k][CW-1], cfg_i.shift[k]}) :
                  {pt_q[k][CW-1], pt_q[k]};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        prod_d[i*3+k] = (cfg_i.inverse ? $signed(matrix_i[k*3+i])
                                       : $signed(matrix_i[i*3+k])) * diff_q[k];
      end
    end
  end

  always_comb begin
    logic signed [SW-1:0] acc;
    for (int i = 0; i < 3; i++) begin
      acc = {{2{prod_q[i*3][PW-1]}}, prod_q[i*3]} +
            {{2{prod_q[i*3+1][PW-1]}}, prod_q[i*3+1]} +
            {{2{prod_q[i*3+2][PW-1]}}, prod_q[i*3+2]} + Half;
      rnd_d[i] = acc[SW-1:rts_pkg::QFrac];
    end
  end

  always_comb begin
    logic signed [TW-1:0] tot;
    logic [TW-CW:0]       top;
    ovf_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      tot = {rnd_q[i][RW-1], rnd_q[i]};
      if (!cfg_i.inverse) begin
        tot = tot + {{(TW-CW){cfg_i.shift[i][CW-1]}}, cfg_i.shift[i]};
      end
      top = tot[TW-1:CW-1];
      if ((&top) || !(|top)) begin
        out_d[i] = tot[CW-1:0];
      end else begin
        out_d[i] = tot[TW-1] ? CMin : CMax;
        ovf_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++) pt_q[k] <= in_point_i[k];
    end
    if (en[2]) begin
      diff_q <= diff_d;
    end
    if (en[3]) begin
      prod_q <= prod_d;
    end
    if (en[4]) begin
      rnd_q <= rnd_d;
    end
    if (en[5]) begin
      out_q <= out_d;
      ovf_q <= ovf_d;
    end
  end

  assign in_ready_o  = en[1];
  assign out_valid_o = vld_q[5];
  assign out_ovf_o   = ovf_q;

  always_comb begin
    for (int k = 0; k < 3; k++) out_point_o[k] = out_q[k];
  end

endmodule

[rtl/core/rigid_transform_point_stream_top.sv]
// Path: each accepted input word passes the input, offset, product, sum and output registers in order.
// Throughput: one point per cycle unless the output stalls; each stage holds only while the stage after it is full.
// Matrix: rebuilt by the two-stage rotation unit, through its product and matrix registers, after a quaternion write.
// Reset: pipeline empty, registers to identity rotation, zero shift, forward mode.
// Top level: config registers, rts_rotation and rts_datapath; depends on rts_pkg.
module rigid_transform_point_stream_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rts_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [rts_pkg::CfgW-1:0]         cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [3*rts_pkg::CoordW-1:0]     s_axis_tdata,  // pt_x, pt_y, pt_z
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [3*rts_pkg::CoordW-1:0]     m_axis_tdata,  // out_x, out_y, out_z
  output logic                             m_axis_tuser   // overflow
);

  localparam int unsigned QW = rts_pkg::QuatW;
  localparam int unsigned CW = rts_pkg::CoordW;
  localparam logic signed [QW-1:0] QuatOne = {2'b01, {(QW-2){1'b0}}};

  rts_pkg::quat_t      quat_q;
  rts_pkg::xform_cfg_t xcfg_q;
  rts_pkg::matrix_t    matrix;
  logic [2:0][CW-1:0]  in_point, out_point;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_q.x       <= '0;
      quat_q.y       <= '0;
      quat_q.z       <= '0;
      quat_q.w       <= QuatOne;
      xcfg_q.shift   <= '0;
      xcfg_q.inverse <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rts_pkg::REG_QUAT_X:  quat_q.x          <= cfg_data_i[QW-1:0];
        rts_pkg::REG_QUAT_Y:  quat_q.y          <= cfg_data_i[QW-1:0];
        rts_pkg::REG_QUAT_Z:  quat_q.z          <= cfg_data_i[QW-1:0];
        rts_pkg::REG_QUAT_W:  quat_q.w          <= cfg_data_i[QW-1:0];
        rts_pkg::REG_SHIFT_X: xcfg_q.shift[0]   <= cfg_data_i[CW-1:0];
        rts_pkg::REG_SHIFT_Y: xcfg_q.shift[1]   <= cfg_data_i[CW-1:0];
        rts_pkg::REG_SHIFT_Z: xcfg_q.shift[2]   <= cfg_data_i[CW-1:0];
        rts_pkg::REG_INVERSE: xcfg_q.inverse    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  rts_rotation u_rotation (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .quat_i   (quat_q),
    .matrix_o (matrix)
  );

  assign in_point     = s_axis_tdata;
  assign m_axis_tdata = out_point;

  rts_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .matrix_i    (matrix),
    .cfg_i       (xcfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_point_i  (in_point),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_point_o (out_point),
    .out_ovf_o   (m_axis_tuser)
  );

endmodule

[rtl/core/rts_checker.sv]
// Port-level checks of the rigid transform point stream, bound to the top level.
// Depends on rts_pkg and rigid_transform_point_stream_top.
module rts_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [3*rts_pkg::CoordW-1:0] m_axis_tdata,
  input logic                         m_axis_tuser
);

  localparam int unsigned CW = rts_pkg::CoordW;
  localparam logic [CW-1:0] CMax = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] CMin = {1'b1, {(CW-1){1'b0}}};

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // an empty or draining output stage never blocks the input
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input blocked with room in the pipeline");

  a_ovf_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[CW-1:0] == CMax || m_axis_tdata[CW-1:0] == CMin ||
      m_axis_tdata[2*CW-1:CW] == CMax || m_axis_tdata[2*CW-1:CW] == CMin ||
      m_axis_tdata[3*CW-1:2*CW] == CMax || m_axis_tdata[3*CW-1:2*CW] == CMin)
    else $error("overflow flag without a clamped coordinate");

endmodule

bind rigid_transform_point_stream_top rts_checker u_rts_checker (.*);

[verif/rigid_transform_point_stream_tb.sv]
`timescale 1ns / 100ps
// Testbench for rigid_transform_point_stream_top: checks every output word against an
// in-bench fixed-point rotate-and-translate predictor. Depends only on rts_pkg and the RTL.
module tb;

  typedef logic [2:0][rts_pkg::CoordW-1:0] coords_t;

  typedef struct packed {
    logic    ovf;
    coords_t xyz;
  } sample_t;

  localparam logic signed [rts_pkg::CoordW-1:0] CMAX = {1'b0, {(rts_pkg::CoordW-1){1'b1}}};
  localparam logic signed [rts_pkg::CoordW-1:0] CMIN = {1'b1, {(rts_pkg::CoordW-1){1'b0}}};
  localparam longint RND_HALF = longint'(1) << (rts_pkg::QFrac - 1);
  localparam longint TERM_MAX = (longint'(1) << (rts_pkg::TermW - 1)) - 1;
  localparam int HOLD_CYCLES = 300;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [rts_pkg::CfgIdxW-1:0]    cfg_index_i = '0;
  logic [rts_pkg::CfgW-1:0]       cfg_data_i = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [3*rts_pkg::CoordW-1:0]   s_axis_tdata = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [3*rts_pkg::CoordW-1:0]   m_axis_tdata;
  logic                           m_axis_tuser;

  rts_pkg::quat_t                 cur_quat;
  logic signed [rts_pkg::CoordW-1:0] cur_shift [3];
  logic                           cur_inverse;
  longint                         rot [9];

  sample_t                 pending_results [$];
  string                   axis_name [3] = '{"x", "y", "z"};
  bit                      tx_gaps_on = 1'b0;
  bit                      rx_stalls_on = 1'b0;
  int                      hold_req = 0;
  int                      hold_ack = 0;
  int                      hold_left = 0;
  int                      stall_left = 0;
  int                      mismatches = 0;
  int                      points_sent = 0;
  int                      results_checked = 0;
  int                      saturated_results = 0;
  int                      settings_used = 0;

  rigid_transform_point_stream_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("** rigid_transform_point_stream_top: FAILED **");
    $finish;
  end

  function automatic longint rot_term(input longint prod_sum, input bit less_one);
    longint v;
    v = 2 * prod_sum;
    if (less_one) v -= longint'(1) << (2 * rts_pkg::QFrac);
    v = (v + RND_HALF) >>> rts_pkg::QFrac;
    if (v > TERM_MAX) v = TERM_MAX;
    else if (v < -TERM_MAX - 1) v = -TERM_MAX - 1;
    return v;
  endfunction

  function automatic void update_matrix();
    longint x, y, z, w;
    x = $signed(cur_quat.x);
    y = $signed(cur_quat.y);
    z = $signed(cur_quat.z);
    w = $signed(cur_quat.w);
    rot[0] = rot_term(w * w + x * x, 1'b1);
    rot[1] = rot_term(x * y - w * z, 1'b0);
    rot[2] = rot_term(x * z + w * y, 1'b0);
    rot[3] = rot_term(x * y + w * z, 1'b0);
    rot[4] = rot_term(w * w + y * y, 1'b1);
    rot[5] = rot_term(y * z - w * x, 1'b0);
    rot[6] = rot_term(x * z - w * y, 1'b0);
    rot[7] = rot_term(y * z + w * x, 1'b0);
    rot[8] = rot_term(w * w + z * z, 1'b1);
  endfunction

  function automatic sample_t transform_point(input coords_t p);
    longint shift_v [3];
    longint d [3];
    longint acc, v;
    sample_t r;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      shift_v[k] = cur_shift[k];
      d[k] = longint'($signed(p[k]));
      if (cur_inverse) d[k] -= shift_v[k];
    end
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int k = 0; k < 3; k++)
        acc += (cur_inverse ? rot[k*3+i] : rot[i*3+k]) * d[k];
      v = (acc + RND_HALF) >>> rts_pkg::QFrac;
      if (!cur_inverse) v += shift_v[i];
      if (v > CMAX) begin
        v = CMAX;
        r.ovf = 1'b1;
      end else if (v < CMIN) begin
        v = CMIN;
        r.ovf = 1'b1;
      end
      r.xyz[i] = v[rts_pkg::CoordW-1:0];
    end
    return r;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [rts_pkg::CoordW-1:0] rand_coord();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: begin
        case (v[1:0])
          2'd0: v = CMAX;
          2'd1: v = CMIN;
          2'd2: v = '0;
          default: v = '1;
        endcase
      end
      1, 2, 3, 4: ;
      default: v = {{10{v[21]}}, v[21:0]};
    endcase
    return v;
  endfunction

  function automatic coords_t rand_point();
    coords_t c;
    for (int k = 0; k < 3; k++) c[k] = rand_coord();
    return c;
  endfunction

  function automatic coords_t pt(input logic [rts_pkg::CoordW-1:0] x, y, z);
    coords_t c;
    c[0] = x;
    c[1] = y;
    c[2] = z;
    return c;
  endfunction

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (rx_stalls_on && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk_i) begin : check_results
    sample_t want;
    sample_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.xyz = m_axis_tdata;
      got.ovf = m_axis_tuser;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: output word with no pending point, actual %h/%b", $time,
                 got.xyz, got.ovf);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.ovf) saturated_results++;
        for (int k = 0; k < 3; k++) begin
          if (got.xyz[k] !== want.xyz[k]) begin
            mismatches++;
            $display("%0t: out_%s expected %0d, actual %0d", $time, axis_name[k],
                     $signed(want.xyz[k]), $signed(got.xyz[k]));
          end
        end
        if (got.ovf !== want.ovf) begin
          mismatches++;
          $display("%0t: overflow expected %b, actual %b", $time, want.ovf, got.ovf);
        end
      end
    end
  end

  task automatic send_point(input coords_t p);
    int gap;
    gap = 0;
    if (tx_gaps_on && $urandom_range(0, 2) == 0) gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= p;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(transform_point(p));
    points_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input rts_pkg::cfg_idx_e idx,
                           input logic [rts_pkg::CfgW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      rts_pkg::REG_QUAT_X:  cur_quat.x = value[rts_pkg::QuatW-1:0];
      rts_pkg::REG_QUAT_Y:  cur_quat.y = value[rts_pkg::QuatW-1:0];
      rts_pkg::REG_QUAT_Z:  cur_quat.z = value[rts_pkg::QuatW-1:0];
      rts_pkg::REG_QUAT_W:  cur_quat.w = value[rts_pkg::QuatW-1:0];
      rts_pkg::REG_SHIFT_X: cur_shift[0] = value;
      rts_pkg::REG_SHIFT_Y: cur_shift[1] = value;
      rts_pkg::REG_SHIFT_Z: cur_shift[2] = value;
      rts_pkg::REG_INVERSE: cur_inverse = value[0];
      default: ;
    endcase
    update_matrix();
  endtask

  // Write quaternion first so the matrix settles while the rest goes in
  task automatic apply_config(input rts_pkg::quat_t q,
                              input logic [rts_pkg::CoordW-1:0] sx, sy, sz,
                              input logic inv);
    drain_results();
    write_reg(rts_pkg::REG_QUAT_X, {16'($urandom), q.x});
    write_reg(rts_pkg::REG_QUAT_Y, {16'($urandom), q.y});
    write_reg(rts_pkg::REG_QUAT_Z, {16'($urandom), q.z});
    write_reg(rts_pkg::REG_QUAT_W, {16'($urandom), q.w});
    write_reg(rts_pkg::REG_SHIFT_X, sx);
    write_reg(rts_pkg::REG_SHIFT_Y, sy);
    write_reg(rts_pkg::REG_SHIFT_Z, sz);
    write_reg(rts_pkg::REG_INVERSE, {31'($urandom), inv});
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic random_config();
    rts_pkg::quat_t q;
    real a, b, c, d, n;
    logic [rts_pkg::CoordW-1:0] s [3];
    if ($urandom_range(0, 4) != 0) begin
      a = real'(int'($urandom_range(0, 2000))) - 1000.0;
      b = real'(int'($urandom_range(0, 2000))) - 1000.0;
      c = real'(int'($urandom_range(0, 2000))) - 1000.0;
      d = real'(int'($urandom_range(0, 2000))) - 1000.0;
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n < 1.0) begin
        d = 1.0;
        n = 1.0;
      end
      q.x = 16'($rtoi(a / n * 16384.0));
      q.y = 16'($rtoi(b / n * 16384.0));
      q.z = 16'($rtoi(c / n * 16384.0));
      q.w = 16'($rtoi(d / n * 16384.0));
    end else begin
      q = rts_pkg::quat_t'({$urandom, $urandom});
    end
    for (int k = 0; k < 3; k++) begin
      s[k] = $urandom;
      if ($urandom_range(0, 9) < 7) s[k] = {{8{s[k][23]}}, s[k][23:0]};
    end
    apply_config(q, s[0], s[1], s[2], 1'($urandom));
  endtask

  task automatic test_reset_identity();
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    send_point(pt('0, '0, '0));
    send_point(pt(CMAX, CMAX, CMAX));
    send_point(pt(CMIN, CMIN, CMIN));
    send_point(pt(32'h0001_0000, '1, 32'd1));
    send_point(pt(CMIN, CMAX, 32'h5555_5555));
  endtask

  task automatic test_directed_extremes();
    // half turn about z: negating the most negative x saturates high
    apply_config(rts_pkg::quat_t'{16'sd0, 16'sd0, 16'sd16384, 16'sd0},
                 '0, '0, '0, 1'b0);
    send_point(pt(CMIN, CMAX, '0));
    send_point(pt(CMAX, CMIN, CMIN));
    apply_config(rts_pkg::quat_t'{16'sd0, 16'sd0, 16'sd0, 16'sd16384},
                 CMAX, CMIN, CMAX, 1'b0);
    send_point(pt(CMAX, CMIN, '0));
    send_point(pt(CMIN, CMAX, CMIN));
    // inverse with p - t beyond a coordinate's range
    apply_config(rts_pkg::quat_t'{16'sd11585, 16'sd0, 16'sd0, 16'sd11585},
                 CMIN, CMAX, CMIN, 1'b1);
    send_point(pt(CMAX, CMIN, CMAX));
    send_point(pt(CMIN, CMAX, CMIN));
    // non-unit quaternions drive the matrix terms into saturation
    apply_config(rts_pkg::quat_t'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000},
                 CMAX, CMAX, CMAX, 1'b1);
    send_point(pt(32'h0000_8000, 32'hFFFF_0000, 32'h0123_4567));
    send_point(rand_point());
    apply_config(rts_pkg::quat_t'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
                 CMIN, CMIN, CMIN, 1'b0);
    send_point(pt(32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000));
    send_point(rand_point());
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 10; phase++) begin
      random_config();
      tx_gaps_on = (phase != 0) && ($urandom_range(0, 3) != 0);
      rx_stalls_on = (phase != 0) && ($urandom_range(0, 3) != 0);
      repeat (110) send_point(rand_point());
    end
  endtask

  task automatic test_backpressure();
    random_config();
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    hold_req <= hold_req + 1;
    repeat (150) send_point(rand_point());
  endtask

  task automatic test_inverse_toggle();
    drain_results();
    write_reg(rts_pkg::REG_INVERSE, {31'($urandom), ~cur_inverse});
    cfg_we_i <= 1'b0;
    settings_used++;
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
    repeat (60) send_point(rand_point());
  endtask

  initial begin
    cur_quat = rts_pkg::quat_t'{16'sd0, 16'sd0, 16'sd0, 16'sd16384};
    for (int k = 0; k < 3; k++) cur_shift[k] = '0;
    cur_inverse = 1'b0;
    update_matrix();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_identity();
    test_directed_extremes();
    test_random_phases();
    test_backpressure();
    test_inverse_toggle();
    drain_results();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d points under %0d register settings, forward and inverse, %0d saturated.",
             points_sent, settings_used, saturated_results);
    $display("Checked %0d output words with %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("** rigid_transform_point_stream_top: PASSED **");
    end else begin
      $display("** rigid_transform_point_stream_top: FAILED **");
    end
    $finish;
  end

endmodule
